// File: rtl/tach_pkg.sv
// ----------------------------------------------------------------------------
// Wheel tachometer package
// Shared widths, reset values, register indexes and state encodings for the
// wheel tachometer and its divider.
// ----------------------------------------------------------------------------
package tach_pkg;

   localparam int COUNT_WIDTH_DEFAULT = 24;

   localparam int TIME_WIDTH    = 32;
   localparam int NUMER_WIDTH   = 24;
   localparam int WINDOW_WIDTH  = 16;
   localparam int SAVE_WIDTH    = 4;
   localparam int SPEED_WIDTH   = 20;
   localparam int ELAPSED_WIDTH = 10;
   localparam int MODE_WIDTH    = 2;
   localparam int CSR_INDEX_WIDTH = 2;
   localparam int CSR_DATA_WIDTH  = 24;

   // The divisor is an interval already known to be below the window.
   localparam int DIVISOR_WIDTH = WINDOW_WIDTH;
   localparam int STEP_WIDTH    = $clog2(NUMER_WIDTH);

   localparam logic [SPEED_WIDTH-1:0]  SPEED_MAX = {SPEED_WIDTH{1'b1}};

   localparam logic [NUMER_WIDTH-1:0]  NUMER_RESET  = NUMER_WIDTH'(995254);
   localparam logic [WINDOW_WIDTH-1:0] WINDOW_RESET = WINDOW_WIDTH'(4000);
   localparam logic [WINDOW_WIDTH-1:0] BLANK_RESET  = WINDOW_WIDTH'(15000);
   localparam logic [SAVE_WIDTH-1:0]   SAVE_RESET   = SAVE_WIDTH'(10);

   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_SPEED_NUMERATOR = 2'd0,
      CSR_VALID_WINDOW    = 2'd1,
      CSR_BLANK_AFTER     = 2'd2,
      CSR_SAVE_INTERVAL   = 2'd3
   } csr_index_type;

   typedef enum logic [MODE_WIDTH-1:0] {
      MODE_NORMAL = 2'd0,
      MODE_IDLE   = 2'd1,
      MODE_BLANK  = 2'd2
   } display_mode_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_INTERVAL,
      S_DECIDE,
      S_DIVIDE,
      S_FINISH
   } state_type;

   typedef enum logic [2:0] {
      KIND_CLEAR,
      KIND_EDGE,
      KIND_BLANK,
      KIND_IDLE,
      KIND_PLAIN
   } sample_kind_type;

endpackage

// File: rtl/tach_div.sv
// ----------------------------------------------------------------------------
// Tachometer divider
// Restoring divider that retires one quotient bit per cycle: one compare and
// subtract of the partial remainder against the divisor.
// ----------------------------------------------------------------------------
module tach_div (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   input  logic [tach_pkg::NUMER_WIDTH-1:0]    dividend,
   input  logic [tach_pkg::DIVISOR_WIDTH-1:0]  divisor,
   output logic                                done,
   output logic [tach_pkg::NUMER_WIDTH-1:0]    quotient
);
   import tach_pkg::*;

   localparam logic [STEP_WIDTH-1:0] LAST_STEP = STEP_WIDTH'(NUMER_WIDTH - 1);

   logic                      busy_ff, busy_in;
   logic                      done_ff, done_in;
   logic [STEP_WIDTH-1:0]     step_ff, step_in;
   logic [DIVISOR_WIDTH-1:0]  rem_ff, rem_in;
   logic [DIVISOR_WIDTH-1:0]  divisor_ff, divisor_in;
   logic [NUMER_WIDTH-1:0]    quot_ff, quot_in;

   logic [DIVISOR_WIDTH:0]    trial;
   logic [DIVISOR_WIDTH:0]    diff;
   logic                      fits;

   // The dividend shifts out of the top of quot_ff while quotient bits
   // shift in at the bottom.
   assign trial = {rem_ff, quot_ff[NUMER_WIDTH-1]};
   assign diff  = trial - {1'b0, divisor_ff};
   assign fits  = trial >= {1'b0, divisor_ff};

   always_comb begin
      busy_in    = busy_ff;
      done_in    = 1'b0;
      step_in    = step_ff;
      rem_in     = rem_ff;
      divisor_in = divisor_ff;
      quot_in    = quot_ff;
      if (start) begin
         busy_in    = 1'b1;
         step_in    = LAST_STEP;
         rem_in     = '0;
         divisor_in = divisor;
         quot_in    = dividend;
      end else if (busy_ff) begin
         rem_in  = fits ? diff[DIVISOR_WIDTH-1:0] : trial[DIVISOR_WIDTH-1:0];
         quot_in = {quot_ff[NUMER_WIDTH-2:0], fits};
         if (step_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            step_in = step_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      step_ff    <= step_in;
      rem_ff     <= rem_in;
      divisor_ff <= divisor_in;
      quot_ff    <= quot_in;
   end

   assign done     = done_ff;
   assign quotient = quot_ff;

endmodule

// File: rtl/wheel_tachometer_unit.sv
// ----------------------------------------------------------------------------
// Wheel tachometer
// Counts wheel rotations from Hall sensor samples, measures speed from the
// interval between falling edges and tracks the record speed.
// ----------------------------------------------------------------------------
// Usage: one sample word enters on the req_ channel per tick and produces
// exactly one result word on the rsp_ channel. The block takes one word at a
// time; req_ready is high only while it waits for a sample.
// A sample that needs no division passes through the interval, decide and
// finish steps to the result register before the next sample can be taken.
// A falling edge inside the valid window with a nonzero interval also runs the
// bit-serial divider, one quotient bit per cycle over 24 bits, between the
// decide and finish steps.
// The result sits in an output register, and the next sample is accepted as
// soon as that word is loaded, even if the receiver has not yet taken it.
// When the receiver stalls, a finished sample waits in its last step until
// the output register frees up, and no later sample is accepted meanwhile.
// The csr_ channel writes the four setting registers and is always ready;
// the user must write it only while the block is idle; the block does not enforce this.
// Reset restores the default settings, clears the clock, count, record and
// speed, and treats the sensor as previously high.
// ----------------------------------------------------------------------------
module wheel_tachometer_unit #(
   parameter int COUNT_WIDTH = tach_pkg::COUNT_WIDTH_DEFAULT
) (
   input  logic                                 clock,
   input  logic                                 reset,

   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic                                 req_sensor_level,
   input  logic                                 req_button_level,
   input  logic [tach_pkg::ELAPSED_WIDTH-1:0]   req_elapsed_ms,

   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic [COUNT_WIDTH-1:0]               rsp_rotation_count,
   output logic [tach_pkg::SPEED_WIDTH-1:0]     rsp_speed_centi_kmh,
   output logic [tach_pkg::SPEED_WIDTH-1:0]     rsp_record_centi_kmh,
   output logic                                 rsp_rotation_seen,
   output logic                                 rsp_save_count_request,
   output logic                                 rsp_save_record_request,
   output logic                                 rsp_cleared,
   output logic [tach_pkg::MODE_WIDTH-1:0]      rsp_display_mode,

   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [tach_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [tach_pkg::CSR_DATA_WIDTH-1:0]  csr_data
);
   import tach_pkg::*;

   localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};

   // Settings
   logic [NUMER_WIDTH-1:0]   numer_ff;
   logic [WINDOW_WIDTH-1:0]  window_ff;
   logic [WINDOW_WIDTH-1:0]  blank_ff;
   logic [SAVE_WIDTH-1:0]    save_int_ff;

   // Tachometer state
   state_type                state_ff, state_in;
   logic [TIME_WIDTH-1:0]    time_ff;
   logic [TIME_WIDTH-1:0]    last_edge_ff;
   logic                     edge_seen_ff;
   logic                     prev_sensor_ff;
   logic [COUNT_WIDTH-1:0]   count_ff;
   logic [SPEED_WIDTH-1:0]   record_ff;
   logic [SAVE_WIDTH-1:0]    save_cnt_ff;
   logic [SPEED_WIDTH-1:0]   last_speed_ff;

   // Per-sample working registers
   logic                     sensor_ff;
   logic                     button_ff;
   logic [TIME_WIDTH-1:0]    interval_ff;
   sample_kind_type          kind_ff, kind_in;
   logic [SPEED_WIDTH-1:0]   speed_ff;

   // Result register
   logic                     rsp_valid_ff;
   logic [COUNT_WIDTH-1:0]   rsp_count_ff;
   logic [SPEED_WIDTH-1:0]   rsp_speed_ff;
   logic [SPEED_WIDTH-1:0]   rsp_record_ff;
   logic                     rsp_seen_ff;
   logic                     rsp_save_cnt_ff;
   logic                     rsp_save_rec_ff;
   logic                     rsp_cleared_ff;
   display_mode_type         rsp_mode_ff;

   // Sequencer controls
   logic                     accept;
   logic                     do_divide;
   logic                     div_start;
   logic                     finish_en;
   logic                     out_free;

   logic                     div_done;
   logic [NUMER_WIDTH-1:0]   div_quotient;

   // Decision terms
   logic                     clear_hit;
   logic                     edge_hit;
   logic                     in_window;
   logic [TIME_WIDTH-1:0]    window_wide;
   logic [TIME_WIDTH-1:0]    blank_wide;

   // Finish-step values
   logic [COUNT_WIDTH-1:0]   count_in;
   logic [SPEED_WIDTH-1:0]   record_in;
   logic [SAVE_WIDTH-1:0]    save_cnt_in;
   logic [SPEED_WIDTH-1:0]   last_speed_in;
   logic [SAVE_WIDTH-1:0]    save_step;
   logic                     save_cnt_req;
   logic                     save_rec_req;
   display_mode_type         mode_in;

   assign csr_ready = 1'b1;

   assign window_wide = {{(TIME_WIDTH - WINDOW_WIDTH){1'b0}}, window_ff};
   assign blank_wide  = {{(TIME_WIDTH - WINDOW_WIDTH){1'b0}}, blank_ff};

   assign clear_hit = !button_ff && ((record_ff != '0) || (count_ff != '0));
   assign edge_hit  = prev_sensor_ff && !sensor_ff;
   assign in_window = edge_seen_ff && (interval_ff < window_wide);

   always_comb begin
      priority if (clear_hit) begin
         kind_in = KIND_CLEAR;
      end else if (edge_hit) begin
         kind_in = KIND_EDGE;
      end else if (interval_ff > blank_wide) begin
         kind_in = KIND_BLANK;
      end else if (interval_ff > window_wide) begin
         kind_in = KIND_IDLE;
      end else begin
         kind_in = KIND_PLAIN;
      end
   end

   assign do_divide = (kind_in == KIND_EDGE) && in_window && (interval_ff != '0);
   assign out_free  = !rsp_valid_ff || rsp_ready;

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) state_in = S_INTERVAL;
         end
         S_INTERVAL: begin
            state_in = S_DECIDE;
         end
         S_DECIDE: begin
            state_in = do_divide ? S_DIVIDE : S_FINISH;
         end
         S_DIVIDE: begin
            if (div_done) state_in = S_FINISH;
         end
         S_FINISH: begin
            if (out_free) state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Sequencer outputs
   always_comb begin
      req_ready = 1'b0;
      div_start = 1'b0;
      finish_en = 1'b0;
      unique case (state_ff)
         S_IDLE:     req_ready = 1'b1;
         S_INTERVAL: ;
         S_DECIDE:   div_start = do_divide;
         S_DIVIDE:   ;
         S_FINISH:   finish_en = out_free;
         default:    ;
      endcase
   end

   assign accept = req_valid && req_ready;

   tach_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (numer_ff),
      .divisor  (interval_ff[DIVISOR_WIDTH-1:0]),
      .done     (div_done),
      .quotient (div_quotient)
   );

   // State update applied when the result word is loaded.
   always_comb begin
      count_in      = count_ff;
      record_in     = record_ff;
      save_cnt_in   = save_cnt_ff;
      last_speed_in = last_speed_ff;
      save_step     = save_cnt_ff + 1'b1;
      save_cnt_req  = 1'b0;
      save_rec_req  = 1'b0;
      mode_in       = MODE_NORMAL;
      unique case (kind_ff)
         KIND_CLEAR: begin
            count_in      = '0;
            record_in     = '0;
            save_cnt_in   = '0;
            last_speed_in = '0;
         end
         KIND_EDGE: begin
            if (count_ff != COUNT_MAX) count_in = count_ff + 1'b1;
            last_speed_in = speed_ff;
            if (save_step >= save_int_ff) begin
               save_cnt_in  = '0;
               save_cnt_req = 1'b1;
            end else begin
               save_cnt_in  = save_step;
            end
            if (speed_ff > record_ff) begin
               record_in    = speed_ff;
               save_rec_req = 1'b1;
            end
         end
         KIND_BLANK: begin
            mode_in       = MODE_BLANK;
            last_speed_in = '0;
         end
         KIND_IDLE: begin
            mode_in       = MODE_IDLE;
            last_speed_in = '0;
         end
         KIND_PLAIN: ;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         numer_ff       <= NUMER_RESET;
         window_ff      <= WINDOW_RESET;
         blank_ff       <= BLANK_RESET;
         save_int_ff    <= SAVE_RESET;
         state_ff       <= S_IDLE;
         time_ff        <= '0;
         last_edge_ff   <= '0;
         edge_seen_ff   <= 1'b0;
         prev_sensor_ff <= 1'b1;
         count_ff       <= '0;
         record_ff      <= '0;
         save_cnt_ff    <= '0;
         last_speed_ff  <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         if (csr_valid && csr_ready) begin
            unique case (csr_index)
               CSR_SPEED_NUMERATOR: numer_ff    <= csr_data[NUMER_WIDTH-1:0];
               CSR_VALID_WINDOW:    window_ff   <= csr_data[WINDOW_WIDTH-1:0];
               CSR_BLANK_AFTER:     blank_ff    <= csr_data[WINDOW_WIDTH-1:0];
               CSR_SAVE_INTERVAL:   save_int_ff <= csr_data[SAVE_WIDTH-1:0];
            endcase
         end

         state_ff <= state_in;

         if (accept) begin
            time_ff <= time_ff + {{(TIME_WIDTH - ELAPSED_WIDTH){1'b0}}, req_elapsed_ms};
         end

         if (finish_en) begin
            count_ff       <= count_in;
            record_ff      <= record_in;
            save_cnt_ff    <= save_cnt_in;
            last_speed_ff  <= last_speed_in;
            prev_sensor_ff <= sensor_ff;
            if (kind_ff == KIND_EDGE) begin
               last_edge_ff <= time_ff;
               edge_seen_ff <= 1'b1;
            end
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Working registers and the result fields other than the valid flag carry no reset.
   always_ff @(posedge clock) begin
      if (accept) begin
         sensor_ff <= req_sensor_level;
         button_ff <= req_button_level;
      end
      if (state_ff == S_INTERVAL) begin
         interval_ff <= time_ff - last_edge_ff;
      end
      if (state_ff == S_DECIDE) begin
         kind_ff <= kind_in;
         // A zero interval inside the window saturates without dividing.
         speed_ff <= (in_window && (interval_ff == '0)) ? SPEED_MAX : '0;
      end
      if (div_done) begin
         speed_ff <= (div_quotient[NUMER_WIDTH-1:SPEED_WIDTH] != '0) ?
                     SPEED_MAX : div_quotient[SPEED_WIDTH-1:0];
      end
      if (finish_en) begin
         rsp_count_ff    <= count_in;
         rsp_speed_ff    <= last_speed_in;
         rsp_record_ff   <= record_in;
         rsp_seen_ff     <= (kind_ff == KIND_EDGE);
         rsp_save_cnt_ff <= save_cnt_req;
         rsp_save_rec_ff <= save_rec_req;
         rsp_cleared_ff  <= (kind_ff == KIND_CLEAR);
         rsp_mode_ff     <= mode_in;
      end
   end

   assign rsp_valid               = rsp_valid_ff;
   assign rsp_rotation_count      = rsp_count_ff;
   assign rsp_speed_centi_kmh     = rsp_speed_ff;
   assign rsp_record_centi_kmh    = rsp_record_ff;
   assign rsp_rotation_seen       = rsp_seen_ff;
   assign rsp_save_count_request  = rsp_save_cnt_ff;
   assign rsp_save_record_request = rsp_save_rec_ff;
   assign rsp_cleared             = rsp_cleared_ff;
   assign rsp_display_mode        = rsp_mode_ff;

endmodule

// File: verif/tach_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Wheel tachometer checker
// Watches the sample, result and register channels of the tachometer, keeps
// its own copy of the settings and the rotation state, predicts one result
// word per accepted sample and compares every result word field by field.
// ----------------------------------------------------------------------------
module tach_checker #(
   parameter int COUNT_WIDTH = tach_pkg::COUNT_WIDTH_DEFAULT
) (
   input  logic                                 clock,
   input  logic                                 reset,

   input  logic                                 req_valid,
   input  logic                                 req_ready,
   input  logic                                 req_sensor_level,
   input  logic                                 req_button_level,
   input  logic [tach_pkg::ELAPSED_WIDTH-1:0]   req_elapsed_ms,

   input  logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   input  logic [COUNT_WIDTH-1:0]               rsp_rotation_count,
   input  logic [tach_pkg::SPEED_WIDTH-1:0]     rsp_speed_centi_kmh,
   input  logic [tach_pkg::SPEED_WIDTH-1:0]     rsp_record_centi_kmh,
   input  logic                                 rsp_rotation_seen,
   input  logic                                 rsp_save_count_request,
   input  logic                                 rsp_save_record_request,
   input  logic                                 rsp_cleared,
   input  logic [tach_pkg::MODE_WIDTH-1:0]      rsp_display_mode,

   input  logic                                 csr_valid,
   input  logic                                 csr_ready,
   input  logic [tach_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [tach_pkg::CSR_DATA_WIDTH-1:0]  csr_data,

   output int                                   failures,
   output int                                   readings_owed,
   output int                                   readings_checked,
   output int                                   edges_total,
   output int                                   clears_total,
   output int                                   records_total,
   output int                                   idles_total,
   output int                                   blanks_total
);
   import tach_pkg::*;

   typedef struct packed {
      logic [COUNT_WIDTH-1:0] count;
      logic [SPEED_WIDTH-1:0] speed;
      logic [SPEED_WIDTH-1:0] best_speed;
      logic                   seen;
      logic                   save_count;
      logic                   save_record;
      logic                   cleared;
      display_mode_type       mode;
   } tach_reading_type;

   // Settings as last written.
   logic [NUMER_WIDTH-1:0]  numerator_cfg;
   logic [WINDOW_WIDTH-1:0] window_cfg;
   logic [WINDOW_WIDTH-1:0] blank_cfg;
   logic [SAVE_WIDTH-1:0]   save_every_cfg;

   // Rotation state of the wheel as this checker sees it.
   logic [TIME_WIDTH-1:0]   ms_clock;
   logic [TIME_WIDTH-1:0]   edge_stamp_ms;
   logic                    had_edge;
   logic                    sensor_prev;
   logic [COUNT_WIDTH-1:0]  rotations;
   logic [SPEED_WIDTH-1:0]  peak_speed;
   logic [SAVE_WIDTH-1:0]   save_ticks;
   logic [SPEED_WIDTH-1:0]  shown_speed;

   tach_reading_type pending_readings[$];
   int fail_count    = 0;
   int checked_count = 0;
   int edge_count    = 0;
   int clear_count   = 0;
   int record_count  = 0;
   int idle_count    = 0;
   int blank_count   = 0;

   function automatic tach_reading_type predict_reading(
      input logic                     sensor,
      input logic                     button,
      input logic [ELAPSED_WIDTH-1:0] elapsed
   );
      tach_reading_type       r;
      logic [TIME_WIDTH-1:0]  interval;
      logic [TIME_WIDTH-1:0]  quotient;
      logic [SPEED_WIDTH-1:0] speed;

      r        = '0;
      r.mode   = MODE_NORMAL;
      ms_clock = ms_clock + TIME_WIDTH'(elapsed);
      interval = ms_clock - edge_stamp_ms;

      if (!button && (peak_speed != '0 || rotations != '0)) begin
         // A press wipes the count and the record; an edge here is dropped.
         rotations   = '0;
         peak_speed  = '0;
         save_ticks  = '0;
         shown_speed = '0;
         r.cleared   = 1'b1;
      end else if (sensor_prev && !sensor) begin
         r.seen = 1'b1;
         speed  = '0;
         if (rotations != {COUNT_WIDTH{1'b1}}) begin
            rotations = rotations + 1'b1;
         end
         if (had_edge && interval < TIME_WIDTH'(window_cfg)) begin
            if (interval == '0) begin
               speed = SPEED_MAX;
            end else begin
               quotient = TIME_WIDTH'(numerator_cfg) / interval;
               speed = (quotient > TIME_WIDTH'(SPEED_MAX)) ? SPEED_MAX
                                                           : quotient[SPEED_WIDTH-1:0];
            end
         end
         shown_speed   = speed;
         edge_stamp_ms = ms_clock;
         had_edge      = 1'b1;
         save_ticks    = save_ticks + 1'b1;
         if (save_ticks >= save_every_cfg) begin
            save_ticks   = '0;
            r.save_count = 1'b1;
         end
         if (speed > peak_speed) begin
            peak_speed    = speed;
            r.save_record = 1'b1;
         end
      end else if (interval > TIME_WIDTH'(blank_cfg)) begin
         r.mode      = MODE_BLANK;
         shown_speed = '0;
      end else if (interval > TIME_WIDTH'(window_cfg)) begin
         r.mode      = MODE_IDLE;
         shown_speed = '0;
      end

      sensor_prev  = sensor;
      r.count      = rotations;
      r.speed      = shown_speed;
      r.best_speed = peak_speed;
      return r;
   endfunction

   function automatic bit field_differs(input string field, input logic [31:0] want,
                                        input logic [31:0] got);
      if (want === got) return 1'b0;
      $display("%0t: %s expected %0d, got %0d", $time, field, want, got);
      return 1'b1;
   endfunction

   always @(posedge clock) begin
      tach_reading_type got;
      tach_reading_type want;
      int               wrong;

      if (reset) begin
         numerator_cfg  = NUMER_RESET;
         window_cfg     = WINDOW_RESET;
         blank_cfg      = BLANK_RESET;
         save_every_cfg = SAVE_RESET;
         ms_clock       = '0;
         edge_stamp_ms  = '0;
         had_edge       = 1'b0;
         sensor_prev    = 1'b1;
         rotations      = '0;
         peak_speed     = '0;
         save_ticks     = '0;
         shown_speed    = '0;
         pending_readings.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            got.count       = rsp_rotation_count;
            got.speed       = rsp_speed_centi_kmh;
            got.best_speed  = rsp_record_centi_kmh;
            got.seen        = rsp_rotation_seen;
            got.save_count  = rsp_save_count_request;
            got.save_record = rsp_save_record_request;
            got.cleared     = rsp_cleared;
            got.mode        = display_mode_type'(rsp_display_mode);
            if (pending_readings.size() == 0) begin
               fail_count++;
               $display("%0t: result word with no prediction waiting, expected none, %s %0d",
                        $time, "got count", got.count);
            end else begin
               want  = pending_readings.pop_front();
               wrong = 0;
               wrong += field_differs("rotation_count", 32'(want.count), 32'(got.count));
               wrong += field_differs("speed_centi_kmh", 32'(want.speed), 32'(got.speed));
               wrong += field_differs("record_centi_kmh", 32'(want.best_speed),
                                      32'(got.best_speed));
               wrong += field_differs("rotation_seen", 32'(want.seen), 32'(got.seen));
               wrong += field_differs("save_count_request", 32'(want.save_count),
                                      32'(got.save_count));
               wrong += field_differs("save_record_request", 32'(want.save_record),
                                      32'(got.save_record));
               wrong += field_differs("cleared", 32'(want.cleared), 32'(got.cleared));
               wrong += field_differs("display_mode", 32'(want.mode), 32'(got.mode));
               fail_count += wrong;
               checked_count++;
            end
         end

         if (csr_valid && csr_ready) begin
            case (csr_index_type'(csr_index))
               CSR_SPEED_NUMERATOR: numerator_cfg  = csr_data[NUMER_WIDTH-1:0];
               CSR_VALID_WINDOW:    window_cfg     = csr_data[WINDOW_WIDTH-1:0];
               CSR_BLANK_AFTER:     blank_cfg      = csr_data[WINDOW_WIDTH-1:0];
               CSR_SAVE_INTERVAL:   save_every_cfg = csr_data[SAVE_WIDTH-1:0];
               default: ;
            endcase
         end

         if (req_valid && req_ready) begin
            want = predict_reading(req_sensor_level, req_button_level, req_elapsed_ms);
            pending_readings.push_back(want);
            edge_count   += want.seen;
            clear_count  += want.cleared;
            record_count += want.save_record;
            idle_count   += (want.mode == MODE_IDLE);
            blank_count  += (want.mode == MODE_BLANK);
         end
      end

      // Outputs move only in the update phase so the stimulus side never races them.
      failures         <= fail_count;
      readings_owed    <= pending_readings.size();
      readings_checked <= checked_count;
      edges_total      <= edge_count;
      clears_total     <= clear_count;
      records_total    <= record_count;
      idles_total      <= idle_count;
      blanks_total     <= blank_count;
   end

endmodule

// File: verif/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Wheel tachometer testbench
// Drives Hall sensor samples through the tachometer under several register
// settings: a short directed run over the corner cases, then shaped random
// rotation runs, idle stretches, button presses and noise, with random
// sender gaps and receiver stalls. A checker predicts and compares results.
// ----------------------------------------------------------------------------
module testbench;
   import tach_pkg::*;

   localparam int CYCLE_LIMIT  = 1000000;
   localparam int PHASE_WORDS  = 275;
   localparam int PHASE_COUNT  = 6;
   localparam int SETTLE_TICKS = 40;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                     req_valid        = 1'b0;
   logic                     req_ready;
   logic                     req_sensor_level = 1'b1;
   logic                     req_button_level = 1'b1;
   logic [ELAPSED_WIDTH-1:0] req_elapsed_ms   = '0;

   logic                     rsp_valid;
   logic                     rsp_ready = 1'b0;
   logic [COUNT_WIDTH_DEFAULT-1:0] rsp_rotation_count;
   logic [SPEED_WIDTH-1:0]   rsp_speed_centi_kmh;
   logic [SPEED_WIDTH-1:0]   rsp_record_centi_kmh;
   logic                     rsp_rotation_seen;
   logic                     rsp_save_count_request;
   logic                     rsp_save_record_request;
   logic                     rsp_cleared;
   logic [MODE_WIDTH-1:0]    rsp_display_mode;

   logic                       csr_valid = 1'b0;
   logic                       csr_ready;
   logic [CSR_INDEX_WIDTH-1:0] csr_index = '0;
   logic [CSR_DATA_WIDTH-1:0]  csr_data  = '0;

   int failures, readings_owed, readings_checked;
   int edges_total, clears_total, records_total, idles_total, blanks_total;

   int  cycle_count    = 0;
   int  words_sent     = 0;
   int  settings_count = 1;
   int  burst_left     = 0;
   bit  gaps_on        = 1'b1;

   logic [15:0] ready_pattern = 16'hFFFF;
   logic [3:0]  pattern_pos   = '0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   wheel_tachometer_unit dut (
      .clock                   (clock),
      .reset                   (reset),
      .req_valid               (req_valid),
      .req_ready               (req_ready),
      .req_sensor_level        (req_sensor_level),
      .req_button_level        (req_button_level),
      .req_elapsed_ms          (req_elapsed_ms),
      .rsp_valid               (rsp_valid),
      .rsp_ready               (rsp_ready),
      .rsp_rotation_count      (rsp_rotation_count),
      .rsp_speed_centi_kmh     (rsp_speed_centi_kmh),
      .rsp_record_centi_kmh    (rsp_record_centi_kmh),
      .rsp_rotation_seen       (rsp_rotation_seen),
      .rsp_save_count_request  (rsp_save_count_request),
      .rsp_save_record_request (rsp_save_record_request),
      .rsp_cleared             (rsp_cleared),
      .rsp_display_mode        (rsp_display_mode),
      .csr_valid               (csr_valid),
      .csr_ready               (csr_ready),
      .csr_index               (csr_index),
      .csr_data                (csr_data)
   );

   tach_checker u_checker (
      .clock                   (clock),
      .reset                   (reset),
      .req_valid               (req_valid),
      .req_ready               (req_ready),
      .req_sensor_level        (req_sensor_level),
      .req_button_level        (req_button_level),
      .req_elapsed_ms          (req_elapsed_ms),
      .rsp_valid               (rsp_valid),
      .rsp_ready               (rsp_ready),
      .rsp_rotation_count      (rsp_rotation_count),
      .rsp_speed_centi_kmh     (rsp_speed_centi_kmh),
      .rsp_record_centi_kmh    (rsp_record_centi_kmh),
      .rsp_rotation_seen       (rsp_rotation_seen),
      .rsp_save_count_request  (rsp_save_count_request),
      .rsp_save_record_request (rsp_save_record_request),
      .rsp_cleared             (rsp_cleared),
      .rsp_display_mode        (rsp_display_mode),
      .csr_valid               (csr_valid),
      .csr_ready               (csr_ready),
      .csr_index               (csr_index),
      .csr_data                (csr_data),
      .failures                (failures),
      .readings_owed           (readings_owed),
      .readings_checked        (readings_checked),
      .edges_total             (edges_total),
      .clears_total            (clears_total),
      .records_total           (records_total),
      .idles_total             (idles_total),
      .blanks_total            (blanks_total)
   );

   // The receiver walks a 16-bit ready pattern and picks a new one on each wrap.
   always @(posedge clock) begin
      rsp_ready   <= ready_pattern[pattern_pos];
      pattern_pos <= pattern_pos + 1'b1;
      if (pattern_pos == 4'd15) begin
         case ($urandom_range(3))
            0:       ready_pattern <= 16'hFFFF;
            1:       ready_pattern <= 16'($urandom);
            2:       ready_pattern <= 16'($urandom & $urandom) | 16'h0001;
            default: ready_pattern <= 16'($urandom | $urandom);
         endcase
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Run timed out after %0d cycles with %0d result words outstanding.",
                  cycle_count, readings_owed);
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   // Holds one sample word on the channel until it is taken, then maybe
   // closes the current burst with a gap.
   task automatic send_word(input logic sensor, input logic button,
                            input logic [ELAPSED_WIDTH-1:0] elapsed);
      req_valid        <= 1'b1;
      req_sensor_level <= sensor;
      req_button_level <= button;
      req_elapsed_ms   <= elapsed;
      do @(posedge clock); while (!req_ready);
      words_sent++;
      if (gaps_on) begin
         if (burst_left == 0) begin
            burst_left = $urandom_range(16, 1);
            req_valid <= 1'b0;
            repeat ($urandom_range(8, 1)) @(posedge clock);
         end else begin
            burst_left--;
         end
      end
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      do @(posedge clock); while (readings_owed != 0);
   endtask

   task automatic write_reg(input csr_index_type idx, input logic [CSR_DATA_WIDTH-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
   endtask

   task automatic write_settings(input logic [NUMER_WIDTH-1:0] numer,
                                 input logic [WINDOW_WIDTH-1:0] window,
                                 input logic [WINDOW_WIDTH-1:0] blank,
                                 input logic [SAVE_WIDTH-1:0] every);
      write_reg(CSR_SPEED_NUMERATOR, CSR_DATA_WIDTH'(numer));
      write_reg(CSR_VALID_WINDOW, CSR_DATA_WIDTH'(window));
      write_reg(CSR_BLANK_AFTER, CSR_DATA_WIDTH'(blank));
      write_reg(CSR_SAVE_INTERVAL, CSR_DATA_WIDTH'(every));
      csr_valid <= 1'b0;
      settings_count++;
   endtask

   // Mostly released; a press now and then clears the count mid-run.
   function automatic logic random_button();
      return ($urandom_range(39) != 0);
   endfunction

   task automatic run_random(input int words);
      int   goal, half, kind, reps, high_len, low_len, ms_cap;
      bit   paused;
      logic level;

      goal   = words_sent + words;
      half   = words_sent + words / 2;
      paused = 1'b0;
      while (words_sent < goal) begin
         kind = $urandom_range(99);
         if (kind < 60) begin
            // A spinning wheel: high and low stretches at a chosen sample pace.
            reps     = $urandom_range(12, 1);
            high_len = $urandom_range(6, 1);
            low_len  = $urandom_range(6, 1);
            ms_cap   = 1023 >> $urandom_range(10);
            repeat (reps) begin
               repeat (high_len) send_word(1'b1, random_button(),
                                           ELAPSED_WIDTH'($urandom_range(ms_cap)));
               repeat (low_len) send_word(1'b0, random_button(),
                                          ELAPSED_WIDTH'($urandom_range(ms_cap)));
            end
         end else if (kind < 75) begin
            // The wheel stops, so the display can go idle and then blank.
            level = 1'($urandom_range(1));
            repeat ($urandom_range(40, 5)) send_word(level, 1'b1,
                                                     ELAPSED_WIDTH'($urandom_range(1023, 500)));
         end else if (kind < 85) begin
            repeat ($urandom_range(3, 1)) send_word(1'($urandom_range(1)), 1'b0,
                                                    ELAPSED_WIDTH'($urandom_range(1023)));
         end else begin
            repeat ($urandom_range(10, 1)) send_word(1'($urandom_range(1)),
                                                     1'($urandom_range(1)),
                                                     ELAPSED_WIDTH'($urandom_range(1023)));
         end
         if (!paused && words_sent >= half) begin
            paused = 1'b1;
            wait_drained();
         end
      end
      wait_drained();
   endtask

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Default settings: first edge, zero interval, a normal speed,
      // idle display, a press on a clean wheel and a press that clears.
      send_word(1'b1, 1'b1, 10'd0);
      send_word(1'b1, 1'b0, 10'd1023);
      send_word(1'b0, 1'b1, 10'd5);
      send_word(1'b1, 1'b1, 10'd0);
      send_word(1'b0, 1'b1, 10'd0);
      send_word(1'b1, 1'b1, 10'd100);
      send_word(1'b0, 1'b1, 10'd100);
      repeat (5) send_word(1'b1, 1'b1, 10'd1023);
      send_word(1'b0, 1'b0, 10'd1023);
      wait_drained();

      // Tight windows and the largest numerator: saturated quotient, a save
      // request on every rotation, idle then blank, a stale edge and two presses.
      write_settings({NUMER_WIDTH{1'b1}}, 16'd600, 16'd1500, 4'd1);
      send_word(1'b1, 1'b1, 10'd0);
      send_word(1'b0, 1'b1, 10'd1);
      send_word(1'b1, 1'b1, 10'd0);
      send_word(1'b0, 1'b1, 10'd1);
      send_word(1'b1, 1'b1, 10'd500);
      send_word(1'b1, 1'b1, 10'd200);
      send_word(1'b1, 1'b1, 10'd1023);
      send_word(1'b0, 1'b1, 10'd0);
      send_word(1'b0, 1'b0, 10'd7);
      send_word(1'b0, 1'b0, 10'd7);
      wait_drained();

      for (int phase = 0; phase < PHASE_COUNT; phase++) begin
         gaps_on = (phase % 3 != 1);
         case (phase)
            0: write_settings(NUMER_RESET, WINDOW_RESET, BLANK_RESET, SAVE_RESET);
            1: write_settings({NUMER_WIDTH{1'b1}}, {WINDOW_WIDTH{1'b1}},
                              {WINDOW_WIDTH{1'b1}}, 4'd15);
            2: write_settings(NUMER_WIDTH'(1), WINDOW_WIDTH'(1), WINDOW_WIDTH'(1), 4'd1);
            3: write_settings(NUMER_WIDTH'($urandom_range({NUMER_WIDTH{1'b1}}, 1)),
                              WINDOW_WIDTH'($urandom_range({WINDOW_WIDTH{1'b1}}, 1)),
                              WINDOW_WIDTH'($urandom_range({WINDOW_WIDTH{1'b1}}, 1)),
                              SAVE_WIDTH'($urandom_range(15, 1)));
            default: write_settings(NUMER_WIDTH'($urandom_range({NUMER_WIDTH{1'b1}}, 1)),
                                    WINDOW_WIDTH'($urandom_range(5000, 200)),
                                    WINDOW_WIDTH'($urandom_range(20000, 5000)),
                                    SAVE_WIDTH'($urandom_range(15, 1)));
         endcase
         run_random(PHASE_WORDS);
      end

      repeat (SETTLE_TICKS) @(posedge clock);

      $display("Sent %0d sample words under %0d register settings; %0d results compared.",
               words_sent, settings_count, readings_checked);
      $display("Saw %0d edges, %0d clears, %0d new records, %0d idle and %0d blank samples.",
               edges_total, clears_total, records_total, idles_total, blanks_total);
      if (failures == 0 && readings_owed == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
